// ----- hdl/erf_rational_approximation_core_macros.svh -----
// assertion macros shared by the checker of the erf core
// no dependencies
`ifndef ERF_RATIONAL_APPROXIMATION_CORE_MACROS_SVH
`define ERF_RATIONAL_APPROXIMATION_CORE_MACROS_SVH

// same-cycle implication, disabled while rstn is low
`define ERFRA_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("erfra check failed");

// next-cycle implication, disabled while rstn is low
`define ERFRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("erfra check failed");

`endif

// ----- hdl/erfra_pkg.sv -----
// types and constants of the erf rational approximation core
// Q30 coefficients, reciprocal table for the exp cells, cell payload structs
package erfra_pkg;

    localparam int QBITS        = 30;
    localparam int IN_FRAC_BITS = 28;
    localparam int IN_SHIFT     = QBITS - IN_FRAC_BITS;
    localparam int EXP_TERMS    = 12;
    localparam int DIV_CELLS    = 31;
    localparam int HRN_CELLS    = 5;
    localparam int RECIP_SHIFT  = 34;

    localparam logic [63:0] Q_ONE = 64'd1 << QBITS;
    localparam logic [63:0] RND   = 64'd1 << (QBITS - 1);

    localparam logic [63:0] BIG_ARG = 64'd6 << QBITS;

    localparam logic [29:0] COEF_P = 30'((64'd3275911 * 64'd1073741824 + 64'd5000000)
                                         / 64'd10000000);
    localparam logic [30:0] LOG2E  = 31'((64'd14426950409 * 64'd1073741824
                                         + 64'd5000000000) / 64'd10000000000);
    localparam logic [29:0] LN2    = 30'((64'd6931471806 * 64'd1073741824
                                         + 64'd5000000000) / 64'd10000000000);

    localparam logic signed [33:0] A0 =  $signed(34'((64'd2548295920 * 64'd1073741824
                                         + 64'd5000000000) / 64'd10000000000));
    localparam logic signed [33:0] A1 = -$signed(34'((64'd2844967360 * 64'd1073741824
                                         + 64'd5000000000) / 64'd10000000000));
    localparam logic signed [33:0] A2 =  $signed(34'((64'd1421413741 * 64'd1073741824
                                         + 64'd500000000) / 64'd1000000000));
    localparam logic signed [33:0] A3 = -$signed(34'((64'd1453152027 * 64'd1073741824
                                         + 64'd500000000) / 64'd1000000000));
    localparam logic signed [33:0] A4 =  $signed(34'((64'd1061405429 * 64'd1073741824
                                         + 64'd500000000) / 64'd1000000000));

    // horner coefficients in cell order, the last cell only multiplies by t
    localparam logic signed [33:0] HRN_COEF [HRN_CELLS] = '{A3, A2, A1, A0, 34'sd0};

    localparam logic [63:0] REC_NUM = 64'd1 << RECIP_SHIFT;

    // ceil(2^34 / k) for k = 12 down to 1
    localparam logic [34:0] EXP_RECIP [EXP_TERMS] = '{
        35'((REC_NUM + 64'd11) / 64'd12),
        35'((REC_NUM + 64'd10) / 64'd11),
        35'((REC_NUM + 64'd9)  / 64'd10),
        35'((REC_NUM + 64'd8)  / 64'd9),
        35'((REC_NUM + 64'd7)  / 64'd8),
        35'((REC_NUM + 64'd6)  / 64'd7),
        35'((REC_NUM + 64'd5)  / 64'd6),
        35'((REC_NUM + 64'd4)  / 64'd5),
        35'((REC_NUM + 64'd3)  / 64'd4),
        35'((REC_NUM + 64'd2)  / 64'd3),
        35'((REC_NUM + 64'd1)  / 64'd2),
        35'(REC_NUM)
    };

    // k / 2 for k = 12 down to 1
    localparam logic [2:0] EXP_HALF [EXP_TERMS] = '{
        3'd6, 3'd5, 3'd5, 3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1, 3'd1, 3'd0
    };

    typedef struct packed {
        logic        neg;
        logic        big;
        logic [31:0] d;
        logic [30:0] e;
    } t_ctx;

    typedef struct packed {
        logic [29:0] u;
        logic [5:0]  n;
        logic [30:0] s;
    } t_exp;

    typedef struct packed {
        logic [32:0] rem;
        logic [30:0] sh;
        logic [30:0] quo;
    } t_div;

    typedef struct packed {
        logic [30:0]        t;
        logic signed [33:0] s;
    } t_hrn;

endpackage

// ----- hdl/erf_rational_approximation_core.sv -----
// erf(x) by the 7.1.26 rational approximation, fully pipelined
// depends on erfra_pkg, erfra_exp_cell, erfra_div_cell, erfra_horner_cell
//
//  channel   direction  signals                         tdata fields (lsb up)
//  s         in         i_s_tvalid o_s_tready i_s_tdata  x_value[31:0]
//  m         out        o_m_tvalid i_m_tready o_m_tdata  erf_value[31:0]
//
// one beat per cycle in and out while the output is not stalled
// the pipeline is the chain: 12 exp cells of 3 stages, 31 divider cells,
// 5 horner cells of 2 stages, plus front, exp shift and final stages
// reset (synchronous, active low) empties every stage and the output slots
// a stalled output fills a one-beat skid slot, then the whole pipeline holds
module erf_rational_approximation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // x_value[31:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata    // erf_value[31:0]
);

    localparam int ET = erfra_pkg::EXP_TERMS;
    localparam int DC = erfra_pkg::DIV_CELLS;
    localparam int HC = erfra_pkg::HRN_CELLS;

    logic ce;

    // front stages
    logic            r0_valid, r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    erfra_pkg::t_ctx r0_ctx, r1_ctx, r2_ctx, r3_ctx, r4_ctx, r5_ctx;
    logic [32:0]     r0_a;
    logic [62:0]     r1_pa;
    logic [65:0]     r1_sq;
    logic [35:0]     r2_q;
    logic [66:0]     r3_y;
    logic [5:0]      r4_n;
    logic [59:0]     r4_ug;
    erfra_pkg::t_exp r5_exp;

    logic            r6_valid;
    erfra_pkg::t_ctx r6_ctx;
    erfra_pkg::t_div r6_div;

    logic            r8_valid;
    erfra_pkg::t_ctx r8_ctx;
    logic            r8_sgn;
    logic [63:0]     r8_fp;

    logic        r9_valid;
    logic [31:0] r9_data;

    logic        r_out_valid, r_skid_valid;
    logic [31:0] r_out_data, r_skid_data;

    // cell chains
    logic            w_ev [ET+1];
    erfra_pkg::t_ctx w_ec [ET+1];
    erfra_pkg::t_exp w_ed [ET+1];
    logic            w_dv [DC+1];
    erfra_pkg::t_ctx w_dc [DC+1];
    erfra_pkg::t_div w_dd [DC+1];
    logic            w_hv [HC+1];
    erfra_pkg::t_ctx w_hc [HC+1];
    erfra_pkg::t_hrn w_hd [HC+1];

    logic [32:0]        n_mag;
    logic [34:0]        n_a;
    logic               n_big;
    erfra_pkg::t_ctx    n_ctx0;
    erfra_pkg::t_ctx    n_ctx2;
    erfra_pkg::t_ctx    n_ctx6;
    logic [31:0]        n_d;
    logic [35:0]        n_q;
    logic [35:0]        n_y;
    logic [29:0]        n_u;
    logic [31:0]        n_es;
    logic [30:0]        n_e;
    logic [32:0]        n_pm;
    logic [33:0]        n_fv;
    logic signed [35:0] n_sv;
    logic signed [35:0] n_m;
    logic [30:0]        n_mag_out;

    assign ce         = ~r_skid_valid;
    assign o_s_tready = ce;

    always_comb begin
        n_mag = i_s_tdata[31] ? (33'h1_0000_0000 - {1'b0, i_s_tdata}) : {1'b0, i_s_tdata};
        n_a   = 35'(n_mag) << erfra_pkg::IN_SHIFT;
        n_big = (n_a >= 35'(erfra_pkg::BIG_ARG));
        n_ctx0.neg = i_s_tdata[31];
        n_ctx0.big = n_big;
        n_ctx0.d   = '0;
        n_ctx0.e   = '0;

        n_d = 32'(erfra_pkg::Q_ONE)
              + 32'((64'(r1_pa) + erfra_pkg::RND) >> erfra_pkg::QBITS);
        n_ctx2   = r1_ctx;
        n_ctx2.d = n_d;
        n_q = 36'((67'(r1_sq) + 67'(erfra_pkg::RND)) >> erfra_pkg::QBITS);
        n_y = 36'((68'(r3_y) + 68'(erfra_pkg::RND)) >> erfra_pkg::QBITS);
        n_u = 30'((61'(r4_ug) + 61'(erfra_pkg::RND)) >> erfra_pkg::QBITS);

        // round-half-up shift by n: ((2s >> n) + 1) >> 1
        n_es = {w_ed[ET].s, 1'b0} >> w_ed[ET].n;
        n_e  = 31'((33'(n_es) + 33'd1) >> 1);
        n_ctx6   = w_ec[ET];
        n_ctx6.e = n_e;

        n_pm = w_hd[HC].s[33] ? 33'(-w_hd[HC].s) : 33'(w_hd[HC].s);
        n_fv = 34'((65'(r8_fp) + 65'(erfra_pkg::RND)) >> erfra_pkg::QBITS);
        n_sv = r8_sgn ? -$signed({2'b00, n_fv}) : $signed({2'b00, n_fv});
        n_m  = $signed(36'(erfra_pkg::Q_ONE)) - n_sv;
        if (r8_ctx.big || n_m > $signed(36'(erfra_pkg::Q_ONE))) begin
            n_mag_out = 31'(erfra_pkg::Q_ONE);
        end else if (n_m < 36'sd0) begin
            n_mag_out = '0;
        end else begin
            n_mag_out = 31'(n_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r8_valid <= 1'b0;
            r9_valid <= 1'b0;
        end else if (ce) begin
            r0_valid <= i_s_tvalid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= w_ev[ET];
            r8_valid <= w_hv[HC];
            r9_valid <= r8_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r0_ctx   <= n_ctx0;
            // arguments past the saturation point run through as zero
            r0_a     <= n_big ? '0 : n_a[32:0];
            r1_ctx   <= r0_ctx;
            r1_pa    <= 63'(erfra_pkg::COEF_P) * 63'(r0_a);
            r1_sq    <= 66'(r0_a) * 66'(r0_a);
            r2_ctx   <= n_ctx2;
            r2_q     <= n_q;
            r3_ctx   <= r2_ctx;
            r3_y     <= 67'(r2_q) * 67'(erfra_pkg::LOG2E);
            r4_ctx   <= r3_ctx;
            r4_n     <= n_y[35:30];
            r4_ug    <= 60'(n_y[29:0]) * 60'(erfra_pkg::LN2);
            r5_ctx   <= r4_ctx;
            r5_exp.u <= n_u;
            r5_exp.n <= r4_n;
            r5_exp.s <= 31'(erfra_pkg::Q_ONE);

            r6_ctx      <= n_ctx6;
            r6_div.rem  <= 33'(erfra_pkg::RND);
            r6_div.sh   <= w_ec[ET].d[31:1];
            r6_div.quo  <= '0;

            r8_ctx <= w_hc[HC];
            r8_sgn <= w_hd[HC].s[33];
            r8_fp  <= 64'(n_pm) * 64'(w_hc[HC].e);

            r9_data <= r8_ctx.neg ? 32'(-{1'b0, n_mag_out}) : 32'({1'b0, n_mag_out});
        end
    end

    assign w_ev[0] = r5_valid;
    assign w_ec[0] = r5_ctx;
    assign w_ed[0] = r5_exp;

    for (genvar j = 0; j < ET; j++) begin : g_exp
        erfra_exp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_recip (erfra_pkg::EXP_RECIP[j]),
            .i_half  (erfra_pkg::EXP_HALF[j]),
            .i_valid (w_ev[j]),
            .i_ctx   (w_ec[j]),
            .i_data  (w_ed[j]),
            .o_valid (w_ev[j+1]),
            .o_ctx   (w_ec[j+1]),
            .o_data  (w_ed[j+1])
        );
    end

    assign w_dv[0] = r6_valid;
    assign w_dc[0] = r6_ctx;
    assign w_dd[0] = r6_div;

    for (genvar j = 0; j < DC; j++) begin : g_div
        erfra_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_valid (w_dv[j]),
            .i_ctx   (w_dc[j]),
            .i_data  (w_dd[j]),
            .o_valid (w_dv[j+1]),
            .o_ctx   (w_dc[j+1]),
            .o_data  (w_dd[j+1])
        );
    end

    // t leaves the divider and enters the polynomial with s = a4
    assign w_hv[0] = w_dv[DC];
    assign w_hc[0] = w_dc[DC];
    assign w_hd[0] = '{t: w_dd[DC].quo, s: erfra_pkg::A4};

    for (genvar j = 0; j < HC; j++) begin : g_hrn
        erfra_horner_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (ce),
            .i_coef  (erfra_pkg::HRN_COEF[j]),
            .i_valid (w_hv[j]),
            .i_ctx   (w_hc[j]),
            .i_data  (w_hd[j]),
            .o_valid (w_hv[j+1]),
            .o_ctx   (w_hc[j+1]),
            .o_data  (w_hd[j+1])
        );
    end

    // output register with a one-beat skid slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid <= r9_valid;
        end else if (r9_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_m_tready) begin
                r_out_data <= r_skid_data;
            end
        end else if (!r_out_valid || i_m_tready) begin
            r_out_data <= r9_data;
        end else begin
            r_skid_data <= r9_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ----- hdl/erfra_exp_cell.sv -----
// one horner term of the exp series: s <= 1 - u*s/k, three register stages
// depends on erfra_pkg
module erfra_exp_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ce,
    input  logic [34:0]       i_recip,
    input  logic [2:0]        i_half,
    input  logic              i_valid,
    input  erfra_pkg::t_ctx   i_ctx,
    input  erfra_pkg::t_exp   i_data,
    output logic              o_valid,
    output erfra_pkg::t_ctx   o_ctx,
    output erfra_pkg::t_exp   o_data
);

    logic            r_a_valid, r_b_valid, r_c_valid;
    erfra_pkg::t_ctx r_a_ctx, r_b_ctx, r_c_ctx;
    logic [29:0]     r_a_u, r_b_u;
    logic [5:0]      r_a_n, r_b_n;
    logic [60:0]     r_a_prod;
    logic [65:0]     r_b_mq;
    erfra_pkg::t_exp r_c_data;

    logic [30:0] n_num;
    logic [30:0] n_quo;

    always_comb begin
        n_num = 31'((62'(r_a_prod) + 62'(erfra_pkg::RND)) >> erfra_pkg::QBITS)
                + 31'(i_half);
        n_quo = r_b_mq[64:erfra_pkg::RECIP_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (i_ce) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a_ctx    <= i_ctx;
            r_a_u      <= i_data.u;
            r_a_n      <= i_data.n;
            r_a_prod   <= 61'(i_data.u) * 61'(i_data.s);
            r_b_ctx    <= r_a_ctx;
            r_b_u      <= r_a_u;
            r_b_n      <= r_a_n;
            r_b_mq     <= 66'(n_num) * 66'(i_recip);
            r_c_ctx    <= r_b_ctx;
            r_c_data.u <= r_b_u;
            r_c_data.n <= r_b_n;
            r_c_data.s <= 31'(erfra_pkg::Q_ONE) - n_quo;
        end
    end

    assign o_valid = r_c_valid;
    assign o_ctx   = r_c_ctx;
    assign o_data  = r_c_data;

endmodule

// ----- hdl/erfra_div_cell.sv -----
// one quotient bit of the restoring divider for t = 2^60 / d
// depends on erfra_pkg
module erfra_div_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ce,
    input  logic              i_valid,
    input  erfra_pkg::t_ctx   i_ctx,
    input  erfra_pkg::t_div   i_data,
    output logic              o_valid,
    output erfra_pkg::t_ctx   o_ctx,
    output erfra_pkg::t_div   o_data
);

    logic            r_valid;
    erfra_pkg::t_ctx r_ctx;
    erfra_pkg::t_div r_data;

    logic [32:0] n_rem2;
    logic [32:0] n_dx;
    logic        n_ge;

    always_comb begin
        n_rem2 = {i_data.rem[31:0], i_data.sh[30]};
        n_dx   = {1'b0, i_ctx.d};
        n_ge   = (n_rem2 >= n_dx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ce) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ctx        <= i_ctx;
            r_data.rem   <= n_ge ? (n_rem2 - n_dx) : n_rem2;
            r_data.sh    <= {i_data.sh[29:0], 1'b0};
            r_data.quo   <= {i_data.quo[29:0], n_ge};
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_data  = r_data;

endmodule

// ----- hdl/erfra_horner_cell.sv -----
// one horner step of the erf polynomial: s <= coef + t*s, two register stages
// depends on erfra_pkg
module erfra_horner_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ce,
    input  logic signed [33:0]    i_coef,
    input  logic                  i_valid,
    input  erfra_pkg::t_ctx       i_ctx,
    input  erfra_pkg::t_hrn       i_data,
    output logic                  o_valid,
    output erfra_pkg::t_ctx       o_ctx,
    output erfra_pkg::t_hrn       o_data
);

    logic            r_a_valid, r_b_valid;
    erfra_pkg::t_ctx r_a_ctx, r_b_ctx;
    logic [30:0]     r_a_t;
    logic            r_a_sgn;
    logic [63:0]     r_a_prod;
    erfra_pkg::t_hrn r_b_data;

    logic              n_neg;
    logic [32:0]       n_ms;
    logic [33:0]       n_v;
    logic signed [33:0] n_sv;

    always_comb begin
        n_neg = i_data.s[33];
        n_ms  = n_neg ? 33'(-i_data.s) : 33'(i_data.s);
        n_v   = 34'((65'(r_a_prod) + 65'(erfra_pkg::RND)) >> erfra_pkg::QBITS);
        n_sv  = r_a_sgn ? -$signed(n_v) : $signed(n_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_ce) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a_ctx    <= i_ctx;
            r_a_t      <= i_data.t;
            r_a_sgn    <= n_neg;
            r_a_prod   <= 64'(i_data.t) * 64'(n_ms);
            r_b_ctx    <= r_a_ctx;
            r_b_data.t <= r_a_t;
            r_b_data.s <= i_coef + n_sv;
        end
    end

    assign o_valid = r_b_valid;
    assign o_ctx   = r_b_ctx;
    assign o_data  = r_b_data;

endmodule

// ----- hdl/erfra_checker.sv -----
// port-level checks for the erf core, bound to the top level
// depends on erf_rational_approximation_core_macros.svh
`include "erf_rational_approximation_core_macros.svh"

module erfra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata
);

    logic [7:0] r_cnt;
    logic [7:0] n_cnt;
    logic       in_beat, out_beat;
    logic       x_seen;
    logic       out_ok;
    logic       out_wait;

    assign in_beat  = i_s_tvalid & o_s_tready;
    assign out_beat = o_m_tvalid & i_m_tready;
    // input data is observed only so the checker sees the whole port set
    assign x_seen   = in_beat & (i_s_tdata[31] | ~i_s_tdata[31]);
    assign out_ok   = ($signed(o_m_tdata) <= 32'sd1073741824) &&
                      ($signed(o_m_tdata) >= -32'sd1073741824);
    assign out_wait = o_m_tvalid & ~i_m_tready;

    always_comb begin
        n_cnt = r_cnt + 8'(x_seen) - 8'(out_beat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // a result beat always belongs to an argument still in flight
    `ERFRA_ASSERT_SAME(a_no_spurious, i_clk, i_rst_n, o_m_tvalid, r_cnt != 8'd0)

    // erf stays within plus or minus one in Q2.30
    `ERFRA_ASSERT_SAME(a_range, i_clk, i_rst_n, o_m_tvalid, out_ok)

    // a stalled result beat holds
    `ERFRA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_wait, o_m_tvalid && $stable(o_m_tdata))

    // reset empties the output
    `ERFRA_ASSERT_NEXT(a_reset, i_clk, 1'b1, !i_rst_n, !o_m_tvalid)

endmodule

bind erf_rational_approximation_core erfra_checker u_erfra_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
